// ----- hdl/evpv_pkg.sv -----
// Shared constants and types for the encoder period velocity block.
package evpv_pkg;

  localparam int TIME_BITS_DEFAULT     = 48;
  localparam int VELOCITY_BITS_DEFAULT = 32;

  // Fixed register field widths
  localparam int LIMIT_BITS = 32;
  localparam int SCALE_BITS = 48;
  localparam int MINV_BITS  = 32;
  localparam int CFG_BITS   = 48;
  localparam int IDX_BITS   = 2;

  // Register indexes
  localparam logic [IDX_BITS-1:0] CFG_MAX_INTERVAL = 2'd0;
  localparam logic [IDX_BITS-1:0] CFG_SCALE        = 2'd1;
  localparam logic [IDX_BITS-1:0] CFG_MIN_VELOCITY = 2'd2;

  // Register reset values
  localparam logic [LIMIT_BITS-1:0] MAX_INTERVAL_RST = 32'd1000000;
  localparam logic [SCALE_BITS-1:0] SCALE_RST        = 48'd65536000;
  localparam logic [MINV_BITS-1:0]  MIN_VELOCITY_RST = 32'd6554;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EDGE,
    ST_DIV,
    ST_EMIT
  } evpv_state_t;

endpackage

// ----- hdl/evpv_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
module evpv_div #(
  parameter int DIVISOR_BITS = evpv_pkg::TIME_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [evpv_pkg::SCALE_BITS-1:0] dividend,
  input  logic [DIVISOR_BITS-1:0]         divisor,
  output logic                            busy,
  output logic                            done,
  output logic [evpv_pkg::SCALE_BITS-1:0] quotient
);

  localparam int QW    = evpv_pkg::SCALE_BITS;
  localparam int CNT_W = $clog2(QW);

  logic [QW-1:0]           quo;
  logic [DIVISOR_BITS-1:0] rem;
  logic [DIVISOR_BITS-1:0] dsr;
  logic [CNT_W-1:0]        count;

  logic [DIVISOR_BITS:0] rem_shift;
  logic [DIVISOR_BITS:0] diff;
  logic                  geq;

  assign rem_shift = {rem, quo[QW-1]};
  assign geq       = rem_shift >= {1'b0, dsr};
  assign diff      = rem_shift - {1'b0, dsr};
  assign quotient  = quo;

  // A zero divisor yields an all-ones quotient, which saturates downstream.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(QW - 1);
      end else if (busy) begin
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[QW-2:0], geq};
      rem <= geq ? diff[DIVISOR_BITS-1:0] : rem_shift[DIVISOR_BITS-1:0];
    end
  end

endmodule

// ----- hdl/encoder_period_velocity.sv -----
// Top level of the encoder period velocity estimator.
//
// One pin sample is taken per input transaction; each accepted sample
// advances a free-running sample clock. A rising edge measures the interval
// since the previous rising edge and returns velocity = velocity_scale /
// interval (unsigned Q16.16, saturated to VELOCITY_BITS), stamped at the
// interval midpoint; an interval longer than twice max_interval_ticks returns
// min_velocity / 2 instead. A pin held steady for max_interval_ticks samples
// returns a timeout result, repeating every max_interval_ticks samples: the
// first gives min_velocity / 2, later ones zero. A sample with no rising edge,
// timeout results included, leaves the block idle. A rising edge with an
// over-long interval passes through ST_EDGE and ST_EMIT only; any other rising
// edge runs the serial divider, 48 steps at one quotient bit per cycle, during
// which no new sample is taken. A sample is only taken while the output
// register is empty or being drained in that cycle. Registers are written
// through cfg_write/cfg_index/cfg_data; the user must write them only while
// the block is idle, as the block does not enforce it; index 3 is ignored.
module encoder_period_velocity #(
  parameter int TIME_BITS     = evpv_pkg::TIME_BITS_DEFAULT,
  parameter int VELOCITY_BITS = evpv_pkg::VELOCITY_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_write,
  input  logic [evpv_pkg::IDX_BITS-1:0]       cfg_index,
  input  logic [evpv_pkg::CFG_BITS-1:0]       cfg_data,
  // pin samples
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                pin_level,
  // results
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [VELOCITY_BITS-1:0]            velocity,
  output logic [TIME_BITS-1:0]                event_time,
  output logic                                is_timeout
);

  localparam int SW    = evpv_pkg::SCALE_BITS;
  localparam int LW    = evpv_pkg::LIMIT_BITS;
  localparam int CMP_W = (TIME_BITS > LW + 1) ? TIME_BITS : LW + 1;
  // Velocity ceiling, held at divider width
  localparam logic [SW-1:0] VEL_MAX_W = {SW{1'b1}} >> (SW - VELOCITY_BITS);

  // Configuration registers
  logic [LW-1:0]                    max_interval_ticks;
  logic [SW-1:0]                    velocity_scale;
  logic [evpv_pkg::MINV_BITS-1:0]   min_velocity;

  // Measurement state
  logic                 previous_level;
  logic [TIME_BITS-1:0] sample_clock;
  logic [TIME_BITS-1:0] last_edge_time;
  logic [LW-1:0]        silence_count;
  logic                 timed_out_before;

  // Edge in progress
  logic [TIME_BITS-1:0]     interval_q;
  logic [TIME_BITS-1:0]     edge_now;
  logic [VELOCITY_BITS-1:0] pend_vel;
  logic [TIME_BITS-1:0]     pend_time;

  evpv_pkg::evpv_state_t state, state_next;

  // Divider
  logic          div_start;
  logic          div_busy;
  logic          div_done;
  logic [SW-1:0] div_quo;

  // Datapath
  logic                     accept;
  logic                     out_free;
  logic                     pin_change;
  logic                     pin_rise;
  logic [LW-1:0]            silence_inc;
  logic                     timeout_hit;
  logic                     too_long;
  logic                     load_timeout;
  logic                     load_emit;
  logic [SW-1:0]            half_min_w;
  logic [VELOCITY_BITS-1:0] half_min_sat;
  logic [VELOCITY_BITS-1:0] quo_sat;

  assign accept      = in_valid && in_ready;
  assign out_free    = !out_valid || out_ready;
  assign pin_change  = pin_level != previous_level;
  assign pin_rise    = pin_level && !previous_level;
  assign silence_inc = silence_count + 1'b1;
  assign timeout_hit = silence_inc >= max_interval_ticks;
  assign too_long    = CMP_W'(interval_q) > CMP_W'({max_interval_ticks, 1'b0});

  assign half_min_w   = SW'(min_velocity >> 1);
  assign half_min_sat = (half_min_w > VEL_MAX_W) ? VELOCITY_BITS'(VEL_MAX_W)
                                                 : VELOCITY_BITS'(half_min_w);
  assign quo_sat      = (div_quo > VEL_MAX_W) ? VELOCITY_BITS'(VEL_MAX_W)
                                              : VELOCITY_BITS'(div_quo);

  evpv_div #(
    .DIVISOR_BITS (TIME_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (velocity_scale),
    .divisor  (interval_q),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      evpv_pkg::ST_IDLE: begin
        if (accept && pin_rise) state_next = evpv_pkg::ST_EDGE;
      end
      evpv_pkg::ST_EDGE: begin
        state_next = too_long ? evpv_pkg::ST_EMIT : evpv_pkg::ST_DIV;
      end
      evpv_pkg::ST_DIV: begin
        if (div_done) state_next = evpv_pkg::ST_EMIT;
      end
      evpv_pkg::ST_EMIT: begin
        if (out_free) state_next = evpv_pkg::ST_IDLE;
      end
      default: state_next = evpv_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready     = (state == evpv_pkg::ST_IDLE) && out_free;
    div_start    = (state == evpv_pkg::ST_EDGE) && !too_long;
    load_timeout = accept && !pin_change && timeout_hit;
    load_emit    = (state == evpv_pkg::ST_EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= evpv_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_interval_ticks <= evpv_pkg::MAX_INTERVAL_RST;
      velocity_scale     <= evpv_pkg::SCALE_RST;
      min_velocity       <= evpv_pkg::MIN_VELOCITY_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        evpv_pkg::CFG_MAX_INTERVAL: max_interval_ticks <= cfg_data[LW-1:0];
        evpv_pkg::CFG_SCALE:        velocity_scale     <= cfg_data[SW-1:0];
        evpv_pkg::CFG_MIN_VELOCITY:
          min_velocity <= cfg_data[evpv_pkg::MINV_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Per-sample state
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level   <= 1'b0;
      sample_clock     <= '0;
      last_edge_time   <= '0;
      silence_count    <= '0;
      timed_out_before <= 1'b0;
    end else if (accept) begin
      sample_clock <= sample_clock + 1'b1;
      if (pin_change) begin
        previous_level   <= pin_level;
        silence_count    <= '0;
        timed_out_before <= 1'b0;
        if (pin_level) last_edge_time <= sample_clock;
      end else if (timeout_hit) begin
        silence_count    <= '0;
        timed_out_before <= 1'b1;
      end else begin
        silence_count <= silence_inc;
      end
    end
  end

  // Edge capture and pending result
  always_ff @(posedge clk) begin
    if (accept && pin_rise) begin
      interval_q <= sample_clock - last_edge_time;
      edge_now   <= sample_clock;
    end
    if (state == evpv_pkg::ST_EDGE) begin
      pend_time <= edge_now - (interval_q >> 1);
      pend_vel  <= half_min_sat;
    end
    if (state == evpv_pkg::ST_DIV && div_done) pend_vel <= quo_sat;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_timeout || load_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_timeout) begin
      velocity   <= timed_out_before ? '0 : half_min_sat;
      event_time <= sample_clock - TIME_BITS'(max_interval_ticks >> 1);
      is_timeout <= 1'b1;
    end else if (load_emit) begin
      velocity   <= pend_vel;
      event_time <= pend_time;
      is_timeout <= 1'b0;
    end
  end

  // Checks
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == evpv_pkg::ST_IDLE) |-> !div_busy)
    else $error("divider busy while idle");

  a_rise_edge: assert property (@(posedge clk) disable iff (rst)
    (accept && pin_level && !previous_level) |=> (state == evpv_pkg::ST_EDGE))
    else $error("rising edge did not start a measurement");

  a_idle_load_timeout: assert property (@(posedge clk) disable iff (rst)
    load_timeout |=> (out_valid && is_timeout))
    else $error("timeout result not flagged");

  a_emit_edge: assert property (@(posedge clk) disable iff (rst)
    load_emit |=> (out_valid && !is_timeout && (state == evpv_pkg::ST_IDLE)))
    else $error("edge result mislabelled");

endmodule

// ----- verif/tb_encoder_period_velocity.sv -----
// Self-checking testbench for the encoder period velocity estimator.
`timescale 1ns / 100ps

module tb_encoder_period_velocity;

  localparam int TW = evpv_pkg::TIME_BITS_DEFAULT;
  localparam int VW = evpv_pkg::VELOCITY_BITS_DEFAULT;
  localparam logic [63:0] SPEED_CEIL = (64'd1 << VW) - 64'd1;
  // Index 3 is decoded by nobody; one write to it must change nothing.
  localparam logic [evpv_pkg::IDX_BITS-1:0] CFG_UNUSED = 2'd3;

  // One velocity estimate as it should leave the block.
  typedef struct {
    logic [VW-1:0] speed;
    logic [TW-1:0] stamp;
    logic          from_timeout;
  } estimate_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_write;
  logic [evpv_pkg::IDX_BITS-1:0] cfg_index;
  logic [evpv_pkg::CFG_BITS-1:0] cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic                          pin_level;
  logic                          out_valid;
  logic                          out_ready;
  logic [VW-1:0]                 velocity;
  logic [TW-1:0]                 event_time;
  logic                          is_timeout;

  encoder_period_velocity u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pin_level  (pin_level),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .velocity   (velocity),
    .event_time (event_time),
    .is_timeout (is_timeout)
  );

  // Estimates still owed by the block, oldest first.
  estimate_t pending_estimates[$];
  int        mismatch_count;

  // Traffic shaping: percentage of cycles each side spends idle, plus a
  // long receiver hold-off counted down by the receiver process itself.
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int phase_no;

  // Mirror of the block: register copies ...
  logic [evpv_pkg::LIMIT_BITS-1:0] limit_q;
  logic [evpv_pkg::SCALE_BITS-1:0] scale_q;
  logic [evpv_pkg::MINV_BITS-1:0]  floor_q;
  // ... and the sampling state.
  logic                  level_q;
  logic [TW-1:0]         clock_q;
  logic [TW-1:0]         last_rise_q;
  logic [32:0]           quiet_q;
  logic                  timed_out_q;

  // Clock: 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: random stalls, or a solid hold-off while hold_left runs down.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    // Keep the log short if something goes badly wrong.
    if (mismatch_count <= 30) $display("[%0t] MISMATCH %s", $realtime, msg);
  endtask

  // Advances the mirror by one pin sample and queues the estimate, if any.
  task automatic estimate_velocity(input logic lvl);
    logic [TW-1:0] span;
    logic [63:0]   quo;
    estimate_t     est;
    if (lvl != level_q) begin
      // Any pin change restarts the silence timer; only a rise measures.
      if (lvl) begin
        span        = clock_q - last_rise_q;
        last_rise_q = clock_q;
        if ({16'd0, span} > {31'd0, limit_q, 1'b0}) begin
          quo = {32'd0, floor_q >> 1};
        end else if (span == '0) begin
          // Only after a full wrap of the sample clock, or a rise on the first sample.
          quo = SPEED_CEIL;
        end else begin
          quo = {16'd0, scale_q} / {16'd0, span};
        end
        est.speed        = (quo > SPEED_CEIL) ? SPEED_CEIL[VW-1:0] : quo[VW-1:0];
        est.stamp        = clock_q - (span >> 1);
        est.from_timeout = 1'b0;
        pending_estimates.push_back(est);
      end
      level_q     = lvl;
      quiet_q     = '0;
      timed_out_q = 1'b0;
    end else begin
      quiet_q = quiet_q + 33'd1;
      if (quiet_q >= {1'b0, limit_q}) begin
        // First timeout reports half the floor, repeats report standstill.
        est.speed        = timed_out_q ? '0 : VW'(floor_q >> 1);
        est.stamp        = clock_q - TW'(limit_q >> 1);
        est.from_timeout = 1'b1;
        pending_estimates.push_back(est);
        timed_out_q = 1'b1;
        quiet_q     = '0;
      end
    end
    clock_q = clock_q + 1'b1;
  endtask

  // Monitor: tracks register writes and accepted samples, and checks every
  // result transaction against the oldest queued estimate.
  always @(posedge clk) begin
    estimate_t want;
    if (rst) begin
      limit_q     = evpv_pkg::MAX_INTERVAL_RST;
      scale_q     = evpv_pkg::SCALE_RST;
      floor_q     = evpv_pkg::MIN_VELOCITY_RST;
      level_q     = 1'b0;
      clock_q     = '0;
      last_rise_q = '0;
      quiet_q     = '0;
      timed_out_q = 1'b0;
      pending_estimates.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          evpv_pkg::CFG_MAX_INTERVAL: limit_q = cfg_data[evpv_pkg::LIMIT_BITS-1:0];
          evpv_pkg::CFG_SCALE:        scale_q = cfg_data[evpv_pkg::SCALE_BITS-1:0];
          evpv_pkg::CFG_MIN_VELOCITY: floor_q = cfg_data[evpv_pkg::MINV_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) estimate_velocity(pin_level);
      if (out_valid && out_ready) begin
        if (pending_estimates.size() == 0) begin
          flag_mismatch($sformatf("unexpected result velocity=%0h time=%0h timeout=%0b",
                                  velocity, event_time, is_timeout));
        end else begin
          want = pending_estimates.pop_front();
          if (velocity !== want.speed)
            flag_mismatch($sformatf("velocity got %0h expected %0h", velocity, want.speed));
          if (event_time !== want.stamp)
            flag_mismatch($sformatf("event_time got %0h expected %0h",
                                    event_time, want.stamp));
          if (is_timeout !== want.from_timeout)
            flag_mismatch($sformatf("is_timeout got %0b expected %0b",
                                    is_timeout, want.from_timeout));
        end
      end
    end
  end

  // Offers one pin sample and returns at the edge where it is taken.
  task automatic send_sample(input logic lvl);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    // Now and then a long gap, so idle time also lands mid-divide.
    if (send_idle_pct != 0 && $urandom_range(0, 49) == 0) gap += $urandom_range(1, 60);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    pin_level <= lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stops offering, waits for every owed estimate, then lets a sample
  // without a result finish before anything else is touched.
  task automatic drain_estimates();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [evpv_pkg::IDX_BITS-1:0] idx,
                           input logic [evpv_pkg::CFG_BITS-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic program_limits(input logic [evpv_pkg::LIMIT_BITS-1:0] lim,
                                input logic [evpv_pkg::SCALE_BITS-1:0] scale,
                                input logic [evpv_pkg::MINV_BITS-1:0]  minv);
    write_reg(evpv_pkg::CFG_MAX_INTERVAL, evpv_pkg::CFG_BITS'(lim));
    write_reg(evpv_pkg::CFG_SCALE, evpv_pkg::CFG_BITS'(scale));
    write_reg(evpv_pkg::CFG_MIN_VELOCITY, evpv_pkg::CFG_BITS'(minv));
    cfg_write <= 1'b0;
  endtask

  // Pin waveform of held levels with random run lengths around the limit,
  // so intervals straddle the over-long threshold; some samples are noise.
  task automatic run_random_samples(input int count,
                                    input logic [evpv_pkg::LIMIT_BITS-1:0] lim);
    int   span_cap;
    int   run_left;
    logic lvl;
    span_cap = (lim > 60) ? 60 : int'(lim);
    run_left = 0;
    lvl      = 1'b0;
    repeat (count) begin
      if ($urandom_range(0, 99) < 15) begin
        send_sample(1'($urandom_range(0, 1)));
      end else begin
        if (run_left == 0) begin
          lvl      = ~lvl;
          run_left = $urandom_range(1, 2 * span_cap + 3);
        end
        run_left--;
        send_sample(lvl);
      end
    end
  endtask

  // Straight after reset: the silence timer has been running since reset,
  // and the first rise measures its interval from time zero.
  task automatic test_silence_from_reset();
    program_limits(32'd3, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    repeat (7) send_sample(1'b0);
    send_sample(1'b1);
    drain_estimates();
  endtask

  // Reset register values, with ordinary short intervals.
  task automatic test_default_limits();
    program_limits(evpv_pkg::MAX_INTERVAL_RST, evpv_pkg::SCALE_RST,
                   evpv_pkg::MIN_VELOCITY_RST);
    send_sample(1'b0);
    send_sample(1'b1);
    send_sample(1'b0);
    send_sample(1'b0);
    send_sample(1'b1);
    drain_estimates();
  endtask

  // Zero limit: every steady sample times out, every rise is over-long.
  task automatic test_zero_limit();
    write_reg(CFG_UNUSED, 48'hA5A5_5A5A_C3C3);
    program_limits(32'd0, 48'd1, 32'd7);
    send_sample(1'b1);
    send_sample(1'b1);
    send_sample(1'b0);
    send_sample(1'b0);
    send_sample(1'b1);
    drain_estimates();
  endtask

  // Intervals of exactly twice the limit and one beyond, floor of zero.
  task automatic test_interval_threshold();
    program_limits(32'd1, 48'd5, 32'd0);
    send_sample(1'b0);
    send_sample(1'b1);
    send_sample(1'b0);
    send_sample(1'b1);
    send_sample(1'b0);
    send_sample(1'b0);
    send_sample(1'b1);
    drain_estimates();
  endtask

  // Receiver goes quiet for a long stretch while samples keep coming, so
  // the output register fills and the input side must stall.
  task automatic test_output_backpressure();
    program_limits(32'd1, 48'h0000_0001_0000, 32'd1000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = 400;
    run_random_samples(20, 32'd1);
    drain_estimates();
  endtask

  // Random limits per phase under one traffic pattern.
  task automatic test_random_traffic(input int snd_pct, input int rcv_pct);
    logic [evpv_pkg::LIMIT_BITS-1:0] lim;
    logic [evpv_pkg::SCALE_BITS-1:0] scale;
    logic [evpv_pkg::MINV_BITS-1:0]  minv;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    repeat (5) begin
      case ($urandom_range(0, 5))
        0:       lim = 32'd1;
        1:       lim = 32'hFFFF_FFFF;
        2:       lim = 32'd0;
        default: lim = $urandom_range(2, 40);
      endcase
      // Make sure the largest limit gets a phase of its own.
      if (phase_no == 0) lim = 32'hFFFF_FFFF;
      case ($urandom_range(0, 3))
        0:       scale = 48'd1;
        1:       scale = 48'hFFFF_FFFF_FFFF;
        2:       scale = {16'd0, 32'($urandom)};
        default: scale = {16'($urandom), 32'($urandom)};
      endcase
      case ($urandom_range(0, 3))
        0:       minv = 32'd0;
        1:       minv = 32'hFFFF_FFFF;
        default: minv = $urandom;
      endcase
      program_limits(lim, scale, minv);
      run_random_samples(50, lim);
      drain_estimates();
      phase_no++;
    end
  endtask

  initial begin
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = evpv_pkg::CFG_MAX_INTERVAL;
    cfg_data       = '0;
    in_valid       = 1'b0;
    pin_level      = 1'b0;
    out_ready      = 1'b0;
    send_idle_pct  = 30;
    recv_idle_pct  = 66;
    hold_left      = 0;
    phase_no       = 0;
    mismatch_count = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_silence_from_reset();
    test_default_limits();
    test_zero_limit();
    test_interval_threshold();
    test_output_backpressure();
    test_random_traffic(30, 66);
    test_random_traffic(66, 30);
    test_random_traffic(0, 0);

    if (pending_estimates.size() != 0)
      flag_mismatch($sformatf("%0d estimates never arrived", pending_estimates.size()));
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
